// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define RSMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RSMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/rsmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Resampler package
// Types and fixed widths shared by the resampler modules.
// ----------------------------------------------------------------------------
package rsmp_pkg;

    localparam int IDX_W      = 6;
    localparam int OUT_DW     = 8;
    localparam int CNT_MAX_W  = 7;
    localparam int WGT_MAX_W  = 32;
    localparam int OFF_MAX_W  = 32;
    localparam int TOT_MAX_W  = WGT_MAX_W + CNT_MAX_W;
    localparam int ADDR_MAX_W = CNT_MAX_W;
    localparam int JOB_SLOTS  = 2;

    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [WGT_MAX_W-1:0]  data;
    } t_wr;

    typedef struct packed {
        logic                 bank;
        logic [CNT_MAX_W-1:0] count;
        logic [TOT_MAX_W-1:0] total;
        logic [OFF_MAX_W-1:0] offset;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_INIT,
        S_FETCH,
        S_SCALE,
        S_ADD,
        S_TEST,
        S_EMIT,
        S_ZERO
    } t_bstate;

endpackage

// ===== sv/rsmp_front.sv =====
// ----------------------------------------------------------------------------
// Resampler front end
// Takes weights, writes them to the current bank and queues finished sets.
// ----------------------------------------------------------------------------
module rsmp_front #(
    parameter int MAX_PARTICLES = 64,
    parameter int WEIGHT_BITS   = 16,
    parameter int OFFSET_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic                   i_last,
    input  logic [OFFSET_BITS-1:0] i_offset,
    output rsmp_pkg::t_wr          o_wr,
    output logic                   o_push,
    output rsmp_pkg::t_job         o_job,
    input  logic                   i_done
);
    import rsmp_pkg::*;

    localparam int IW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int TW = WEIGHT_BITS + CW;
    localparam int OW = $clog2(JOB_SLOTS + 1);

    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_total, n_total;
    logic          r_bank, n_bank;
    logic [OW-1:0] r_outst, n_outst;

    logic          accept;
    logic          room;
    logic [CW-1:0] cnt_add;
    logic [TW-1:0] tot_add;

    always_comb begin
        o_ready = r_outst < OW'(JOB_SLOTS);
        accept  = i_valid && o_ready;
        room    = r_count < CW'(MAX_PARTICLES);
        cnt_add = r_count + CW'(room);
        tot_add = r_total + (room ? TW'(i_weight) : '0);

        o_wr.en   = accept && room;
        o_wr.addr = ADDR_MAX_W'({r_bank, r_count[IW-1:0]});
        o_wr.data = WGT_MAX_W'(i_weight);

        o_push       = accept && i_last;
        o_job.bank   = r_bank;
        o_job.count  = CNT_MAX_W'(cnt_add);
        o_job.total  = TOT_MAX_W'(tot_add);
        o_job.offset = OFF_MAX_W'(i_offset);

        n_count = r_count;
        n_total = r_total;
        n_bank  = r_bank;
        if (accept) begin
            if (i_last) begin
                n_count = '0;
                n_total = '0;
                n_bank  = !r_bank;
            end else begin
                n_count = cnt_add;
                n_total = tot_add;
            end
        end
        n_outst = r_outst + OW'(o_push) - OW'(i_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_bank  <= 1'b0;
            r_outst <= '0;
        end else begin
            r_count <= n_count;
            r_total <= n_total;
            r_bank  <= n_bank;
            r_outst <= n_outst;
        end
    end

endmodule

// ===== sv/rsmp_queue.sv =====
// ----------------------------------------------------------------------------
// Resampler set queue
// Two-entry FIFO of loaded sets between the front and back ends.
// ----------------------------------------------------------------------------
module rsmp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rsmp_pkg::t_job i_job,
    input  logic           i_pop,
    output rsmp_pkg::t_job o_job,
    output logic           o_empty
);
    import rsmp_pkg::*;

    localparam int PW = $clog2(JOB_SLOTS);
    localparam int FW = $clog2(JOB_SLOTS + 1);

    t_job          r_slot [JOB_SLOTS];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [FW-1:0] r_fill;

    assign o_job   = r_slot[r_rptr];
    assign o_empty = (r_fill == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_fill <= r_fill + FW'(i_push) - FW'(i_pop);
        end
    end

endmodule

// ===== sv/rsmp_back.sv =====
// ----------------------------------------------------------------------------
// Resampler back end
// Holds the weight memory and walks particles and slots for each queued set.
// ----------------------------------------------------------------------------
module rsmp_back #(
    parameter int MAX_PARTICLES = 64,
    parameter int WEIGHT_BITS   = 16,
    parameter int OFFSET_BITS   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rsmp_pkg::t_wr              i_wr,
    input  rsmp_pkg::t_job             i_job,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_done,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rsmp_pkg::IDX_W-1:0] o_index,
    output logic                       o_last,
    output logic                       o_err
);
    import rsmp_pkg::*;

    localparam int IW  = $clog2(MAX_PARTICLES);
    localparam int CW  = $clog2(MAX_PARTICLES + 1);
    localparam int TW  = WEIGHT_BITS + CW;
    localparam int AW  = OFFSET_BITS + TW;
    localparam int PW  = WEIGHT_BITS + CW;
    localparam int DW  = TW + CW + OFFSET_BITS + 2;
    localparam int BW  = $clog2(OFFSET_BITS);
    localparam int MD  = 2 * (2 ** IW);

    logic [WEIGHT_BITS-1:0] r_mem [MD];
    logic [WEIGHT_BITS-1:0] r_rd_data;

    t_bstate                r_state, n_state;
    logic                   r_bank, n_bank;
    logic [CW-1:0]          r_n, n_n;
    logic [TW-1:0]          r_total, n_total;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [AW-1:0]          r_acc, n_acc;
    logic [BW-1:0]          r_bit, n_bit;
    logic signed [DW-1:0]   r_d, n_d;
    logic [IW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_slot, n_slot;
    logic [PW-1:0]          r_prod, n_prod;
    logic [IW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_out_valid, n_out_valid;
    logic [IW-1:0]          r_out_idx, n_out_idx;
    logic                   r_out_last, n_out_last;
    logic                   r_out_err, n_out_err;

    logic out_free;
    logic reached;
    logic end_walk;
    logic last_slot;

    always_comb begin
        out_free  = !r_out_valid || i_ready;
        reached   = !r_d[DW-1];
        end_walk  = (CW'(r_j) + CW'(1)) >= r_n;
        last_slot = (r_slot + CW'(1)) == r_n;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_job.total[TW-1:0] == '0) ? S_ZERO : S_MUL;
                end
            end
            S_MUL: begin
                if (r_bit == BW'(OFFSET_BITS - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT:  n_state = S_SCALE;
            S_FETCH: n_state = S_SCALE;
            S_SCALE: n_state = S_ADD;
            S_ADD:   n_state = S_TEST;
            S_TEST:  n_state = (reached || end_walk) ? S_EMIT : S_FETCH;
            S_EMIT: begin
                if (out_free) begin
                    n_state = last_slot ? S_IDLE : S_TEST;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_bank      = r_bank;
        n_n         = r_n;
        n_total     = r_total;
        n_off       = r_off;
        n_acc       = r_acc;
        n_bit       = r_bit;
        n_d         = r_d;
        n_j         = r_j;
        n_slot      = r_slot;
        n_prod      = r_prod;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        o_pop       = 1'b0;
        o_done      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_bank   = i_job.bank;
                    n_n      = i_job.count[CW-1:0];
                    n_total  = i_job.total[TW-1:0];
                    n_off    = i_job.offset[OFFSET_BITS-1:0];
                    n_acc    = '0;
                    n_bit    = '0;
                    n_slot   = '0;
                    n_rd_idx = '0;
                end
            end
            S_MUL: begin
                n_acc = (r_acc << 1) + (r_off[OFFSET_BITS-1] ? AW'(r_total) : '0);
                n_off = r_off << 1;
                n_bit = r_bit + BW'(1);
            end
            S_INIT: begin
                n_d = -$signed(DW'(r_acc));
            end
            S_SCALE: begin
                n_prod = PW'(r_rd_data) * PW'(r_n);
            end
            S_ADD: begin
                n_d = r_d + $signed(DW'(r_prod) << OFFSET_BITS);
                n_j = r_rd_idx;
            end
            S_TEST: begin
                if (!(reached || end_walk)) begin
                    n_rd_idx = r_j + IW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_j;
                    n_out_last  = last_slot;
                    n_out_err   = 1'b0;
                    n_d         = r_d - $signed(DW'(r_total) << OFFSET_BITS);
                    n_slot      = r_slot + CW'(1);
                    o_done      = last_slot;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    o_done      = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_ready;
            end
        endcase
        o_valid = r_out_valid;
        o_index = IDX_W'(r_out_idx);
        o_last  = r_out_last;
        o_err   = r_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[IW:0]] <= i_wr.data[WEIGHT_BITS-1:0];
        end
        r_rd_data <= r_mem[{r_bank, r_rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bank     <= n_bank;
        r_n        <= n_n;
        r_total    <= n_total;
        r_off      <= n_off;
        r_acc      <= n_acc;
        r_bit      <= n_bit;
        r_d        <= n_d;
        r_j        <= n_j;
        r_slot     <= n_slot;
        r_prod     <= n_prod;
        r_rd_idx   <= n_rd_idx;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

endmodule

// ===== sv/systematic_resampler.sv =====
// ----------------------------------------------------------------------------
// Systematic resampler
// Loads a set of particle weights and returns one ancestor index per particle.
// ----------------------------------------------------------------------------
// Weights arrive on the slave stream, one per transaction; tlast marks the
// final weight, whose transaction also carries the random fraction. Weights
// beyond MAX_PARTICLES are dropped, but their tlast still closes the set.
// The master stream returns one index per loaded weight, with tlast on the
// final one. If all weights are zero a single transaction with tuser set,
// index zero and tlast is returned instead.
// Loading takes one weight per cycle while s_axis_tready is high. Resampling
// starts with a bit-serial shift-and-add product of the total and the random
// fraction, then fetches, scales and adds the weight of each particle the
// walk steps over and emits one index per slot. Weights sit in a two-bank
// memory, so the next set loads while the current one is resampled; the
// slave side stalls only when two sets are waiting or in progress.
// Reset empties both banks' bookkeeping and the output register. When the
// receiver stalls, the output register holds its transaction and the walk
// waits.
module systematic_resampler #(
    parameter int MAX_PARTICLES = 64,
    parameter int WEIGHT_BITS   = 16,
    parameter int OFFSET_BITS   = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // weight, random_offset
    input  logic [((WEIGHT_BITS+OFFSET_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                       s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // ancestor_index
    output logic [rsmp_pkg::OUT_DW-1:0]                m_axis_tdata,
    output logic                                       m_axis_tlast,
    // all_zero_error
    output logic                                       m_axis_tuser
);
    import rsmp_pkg::*;

    t_wr              wr;
    t_job             push_job;
    t_job             head_job;
    logic             push;
    logic             pop;
    logic             empty;
    logic             done;
    logic [IDX_W-1:0] index;

    rsmp_front #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_weight(s_axis_tdata[WEIGHT_BITS-1:0]),
        .i_last  (s_axis_tlast),
        .i_offset(s_axis_tdata[WEIGHT_BITS +: OFFSET_BITS]),
        .o_wr    (wr),
        .o_push  (push),
        .o_job   (push_job),
        .i_done  (done)
    );

    rsmp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .i_pop  (pop),
        .o_job  (head_job),
        .o_empty(empty)
    );

    rsmp_back #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (wr),
        .i_job  (head_job),
        .i_empty(empty),
        .o_pop  (pop),
        .o_done (done),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_index(index),
        .o_last (m_axis_tlast),
        .o_err  (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DW - IDX_W){1'b0}}, index};

endmodule

// ===== sv/rsmp_checker.sv =====
// ----------------------------------------------------------------------------
// Resampler port checker
// Watches the result stream of the resampler over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsmp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rsmp_pkg::OUT_DW-1:0]   m_axis_tdata,
    input logic                          m_axis_tlast,
    input logic                          m_axis_tuser
);
    `RSMP_ASSERT(a_valid_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")

    `RSMP_ASSERT(a_payload_held, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "payload changed")

    `RSMP_ASSERT(a_error_shape, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "bad error result")

    `RSMP_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

endmodule

bind systematic_resampler rsmp_checker u_rsmp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Systematic resampler testbench
// Streams sets of particle weights into the resampler and checks every
// ancestor index it returns against an exact integer prediction. A short
// directed part covers single weights, all-zero sets and extreme weights and
// fractions; random sets of mixed shape follow under several idling patterns,
// with one long receiver hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module tb_top;

    import rsmp_pkg::*;

    class resample_scoreboard;

        localparam int MAX_N = 64;

        typedef struct {
            logic [IDX_W-1:0] index;
            logic             last;
            logic             zero_err;
        } t_slot_result;

        logic [15:0]       weight_mem [MAX_N];
        int unsigned       held;
        longint unsigned   total;
        t_slot_result      expected_q [$];
        int unsigned       errors;
        int unsigned       weights_in;
        int unsigned       indices_out;
        int unsigned       sets_done;
        int unsigned       zero_sets;
        int unsigned       overflow_sets;
        int unsigned       dropped;

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_input(logic [15:0] w, logic lst, logic [15:0] r);
            longint unsigned cum;
            longint unsigned n;
            longint unsigned rr;
            longint unsigned slot;
            longint unsigned j;
            t_slot_result    res;
            weights_in++;
            if (held < MAX_N) begin
                weight_mem[held] = w;
                held++;
                total += 64'(w);
            end else begin
                dropped++;
            end
            if (!lst) begin
                return;
            end
            sets_done++;
            if (dropped != 0) begin
                overflow_sets++;
            end
            n  = 64'(held);
            rr = 64'(r);
            if (total == 0) begin
                res.index    = '0;
                res.last     = 1'b1;
                res.zero_err = 1'b1;
                expected_q.push_back(res);
                zero_sets++;
            end else begin
                j   = 0;
                cum = 64'(weight_mem[0]);
                for (slot = 0; slot < n; slot++) begin
                    while (((cum * n) << 16) < ((rr + (slot << 16)) * total)
                           && j + 1 < n) begin
                        j++;
                        cum += 64'(weight_mem[j]);
                    end
                    res.index    = j[IDX_W-1:0];
                    res.last     = (slot + 1 == n);
                    res.zero_err = 1'b0;
                    expected_q.push_back(res);
                end
            end
            held    = 0;
            total   = 0;
            dropped = 0;
        endfunction

        task check_result(logic [OUT_DW-1:0] data, logic lst, logic usr);
            t_slot_result exp_r;
            indices_out++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transaction index=%0d last=%0b err=%0b",
                                 data, lst, usr));
            end else begin
                exp_r = expected_q.pop_front();
                if (data !== {{(OUT_DW-IDX_W){1'b0}}, exp_r.index}) begin
                    report($sformatf("ancestor index %0d, expected %0d", data,
                                     exp_r.index));
                end
                if (lst !== exp_r.last) begin
                    report($sformatf("tlast %0b, expected %0b", lst, exp_r.last));
                end
                if (usr !== exp_r.zero_err) begin
                    report($sformatf("zero-weight flag %0b, expected %0b", usr,
                                     exp_r.zero_err));
                end
            end
        endtask

    endclass

    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_SPARSE,
        MIX_SPIKE,
        MIX_ZERO
    } t_weight_mix;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              s_axis_tvalid  = 1'b0;
    logic              s_axis_tready;
    // weight [15:0], random_offset [31:16]
    logic [31:0]       s_axis_tdata   = '0;
    logic              s_axis_tlast   = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready  = 1'b0;
    // ancestor_index [5:0], zero padding [7:6]
    logic [OUT_DW-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    // all_zero_error [0]
    logic              m_axis_tuser;

    resample_scoreboard sb = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_start     = 1'b0;
    logic        hold_taken     = 1'b0;
    int          stall_left     = 0;
    int unsigned items_sent     = 0;
    int unsigned random_sets    = 0;
    logic [15:0] set_weights [$];

    systematic_resampler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_start && !hold_taken) begin
            hold_taken    <= 1'b1;
            stall_left    <= 800;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    task send_item(logic [15:0] w, logic lst, logic [15:0] r);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, w};
        s_axis_tlast  <= lst;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_input(w, lst, r);
        items_sent++;
    endtask

    // The fraction only counts on the final transaction, so it is patched in.
    task send_set(logic [15:0] r);
        logic [15:0] tail;
        int unsigned k;
        tail = set_weights[set_weights.size() - 1];
        set_weights.delete(set_weights.size() - 1);
        for (k = 0; k < set_weights.size(); k++) begin
            send_item(set_weights[k], 1'b0, 16'($urandom_range(65535)));
        end
        send_item(tail, 1'b1, r);
        set_weights.delete();
    endtask

    function logic [15:0] pick_weight(t_weight_mix mix);
        case (mix)
            MIX_FULL:   pick_weight = 16'($urandom_range(65535));
            MIX_SMALL:  pick_weight = 16'($urandom_range(15));
            MIX_SPARSE: pick_weight = ($urandom_range(3) == 0) ?
                                      16'($urandom_range(65535)) : 16'd0;
            MIX_SPIKE:  pick_weight = ($urandom_range(9) == 0) ?
                                      16'hFFFF : 16'($urandom_range(3));
            default:    pick_weight = 16'd0;
        endcase
    endfunction

    task send_random_set();
        int unsigned size;
        int unsigned k;
        int unsigned sel;
        t_weight_mix mix;
        logic [15:0] r;
        sel = $urandom_range(9);
        if (sel <= 3) begin
            mix = MIX_FULL;
        end else if (sel <= 5) begin
            mix = MIX_SMALL;
        end else if (sel <= 7) begin
            mix = MIX_SPARSE;
        end else if (sel == 8) begin
            mix = MIX_SPIKE;
        end else begin
            mix = MIX_ZERO;
        end
        if (random_sets == 2) begin
            size = 64;
        end else if (random_sets == 4) begin
            size = 67;
        end else if ($urandom_range(24) == 0) begin
            size = $urandom_range(70, 60);
        end else begin
            size = $urandom_range(10, 1);
        end
        sel = $urandom_range(9);
        r = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(65535));
        for (k = 0; k < size; k++) begin
            set_weights.push_back(pick_weight(mix));
        end
        send_set(r);
        random_sets++;
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int phase;
        int unsigned phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_weights = {16'd65535};
        send_set(16'd0);
        set_weights = {16'd0, 16'd0, 16'd0};
        send_set(16'd12345);
        set_weights = {16'd0};
        send_set(16'hFFFF);
        set_weights = {16'd0, 16'd65535, 16'd0, 16'd1, 16'd65535};
        send_set(16'hFFFF);
        set_weights = {16'd1, 16'd1};
        send_set(16'h8000);
        set_weights = {16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
        send_set(16'd1);
        set_weights = {16'd0, 16'd0, 16'd0, 16'd5};
        send_set(16'd0);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                    hold_start <= 1'b1;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 84;
                end
                default: begin
                    send_idle_pct = 36;
                    recv_stall_pct <= 36;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 45) begin
                send_random_set();
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        $display("Covered %0d weight sets (%0d all-zero, %0d over capacity) from %0d weights,",
                 sb.sets_done, sb.zero_sets, sb.overflow_sets, sb.weights_in);
        $display("returning %0d index transactions under four idling patterns and one hold-off.",
                 sb.indices_out);
        if (sb.errors == 0) begin
            $display("** systematic_resampler: PASSED **");
        end else begin
            $display("** systematic_resampler: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding.", sb.pending());
        $display("** systematic_resampler: FAILED **");
        $finish;
    end

endmodule
